[design/npp_pkg.sv]
// -----------------------------------------------------------------------------
// npp_pkg: nearest neighbour path planner shared definitions
// Status codes, opcodes, state codes, length format and default sizes.
// -----------------------------------------------------------------------------
package npp_pkg;

    localparam int MAX_PADS_DEF   = 1024;
    localparam int COORD_BITS_DEF = 12;

    localparam int LEN_W     = 31;
    localparam int FRAC_BITS = 8;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CLR  = 9'b000000010,
        S_TSET = 9'b000000100,
        S_SCAN = 9'b000001000,
        S_SQRT = 9'b000010000,
        S_ACC  = 9'b000100000,
        S_COPY = 9'b001000000,
        S_NEXT = 9'b010000000,
        S_RD   = 9'b100000000
    } t_state;

endpackage

[design/nearest_neighbour_path_planner_unit.sv]
// -----------------------------------------------------------------------------
// nearest_neighbour_path_planner_unit
// Loads pads, solves a greedy nearest neighbour open path, serves path reads.
// -----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------
//  in       | input     | i_in_valid / o_in_ready   | operation, pad_x/y, last_pad,
//           |           |                           | position
//  out      | output    | o_out_valid / i_out_ready | status, pad_index, pad_count,
//           |           |                           | path_length
//  cfg      | input     | i_cfg_we (no wait)        | algorithm mode
//
// A plain load beat, or one on a rejected list, gives its result in the next cycle;
// a read beat passes S_RD first. A closing load runs the solve: each tour clears
// visited marks, sets the start, then per step scans, takes a 21-bit root (12-bit
// coordinates) and adds it; a path no longer than the best is copied. Mode 1 runs a
// tour per pad, abandoned ones end early. The search, one pad per cycle, sets the pace.
// Sync active-low reset clears control state only; a stalled result holds o_in_ready low.
// -----------------------------------------------------------------------------
module nearest_neighbour_path_planner_unit #(
    parameter int MAX_PADS   = npp_pkg::MAX_PADS_DEF,
    parameter int COORD_BITS = npp_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [11:0] i_pad_x,
    input  logic [11:0] i_pad_y,
    input  logic        i_last_pad,
    input  logic [9:0]  i_position,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [9:0]  o_pad_index,
    output logic [10:0] o_pad_count,
    output logic [30:0] o_path_length
);

    localparam int IDX_W = $clog2(MAX_PADS);
    localparam int CNT_W = $clog2(MAX_PADS + 1);
    localparam int CB    = COORD_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int D_W   = SQ_W + 1;
    localparam int V_W   = D_W + 2 * npp_pkg::FRAC_BITS;
    localparam int R_W   = (V_W + 1) / 2;
    localparam int IT_W  = $clog2(R_W + 1);
    localparam int LW    = npp_pkg::LEN_W;

    // memories
    logic [CB-1:0]    x_mem    [MAX_PADS];
    logic [CB-1:0]    y_mem    [MAX_PADS];
    logic             vis_mem  [MAX_PADS];
    logic [IDX_W-1:0] cur_mem  [MAX_PADS];
    logic [IDX_W-1:0] best_mem [MAX_PADS];

    npp_pkg::t_state r_state;

    // list state
    logic [CNT_W-1:0] r_count;
    logic             r_closed, r_solved, r_ovf, r_mode, r_run_mode;
    logic [LW-1:0]    r_best, r_running;
    logic [IDX_W-1:0] r_idx;

    // tour control
    logic [CNT_W-1:0] r_s, r_k, r_j, r_c;
    logic [CB-1:0]    r_lx, r_ly;

    // scan pipeline
    logic             r_v1, r_v2, r_vis2;
    logic [IDX_W-1:0] r_j1, r_j2;
    logic [CB-1:0]    r_x2, r_y2;
    logic [SQ_W-1:0]  r_sqx, r_sqy;
    logic             r_found;
    logic [D_W-1:0]   r_bestd;
    logic [IDX_W-1:0] r_pick;
    logic [CB-1:0]    r_px, r_py;

    // root unit
    logic [2*R_W-1:0] r_sv;
    logic [R_W+1:0]   r_rem;
    logic [R_W-1:0]   r_root;
    logic [IT_W-1:0]  r_it;

    // copy pipeline
    logic             r_cv;
    logic [IDX_W-1:0] r_c1;

    // read data
    logic [CB-1:0]    x_q, y_q;
    logic             vis_q;
    logic [IDX_W-1:0] cur_q, best_q;

    // output register
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [IDX_W-1:0] r_out_idx;
    logic [LW-1:0]    r_out_len;

    logic             in_acc;
    logic [CNT_W-1:0] eff_count;
    logic             eff_ovf, ld_full, ld_store, ld_ovf;
    logic [IDX_W-1:0] st_addr;
    logic [CB-1:0]    dx, dy;
    logic [D_W-1:0]   sum_d;
    logic [R_W+3:0]   rem_sh, trial;
    logic [LW:0]      acc_sum;
    logic [LW-1:0]    n_running;
    logic             abandon;
    logic [CNT_W-1:0] starts;
    logic             vis_we, vis_d, cur_we;
    logic [IDX_W-1:0] vis_wa, cur_wa, cur_wd, rd_addr;

    assign o_in_ready = (r_state == npp_pkg::S_IDLE) && !r_out_valid;
    assign in_acc     = i_in_valid && o_in_ready;

    // load decode: a closed list is cleared before the pad is taken
    assign eff_count = r_closed ? '0 : r_count;
    assign eff_ovf   = r_closed ? 1'b0 : r_ovf;
    assign ld_full   = 32'(eff_count) >= 32'(MAX_PADS);
    assign ld_ovf    = eff_ovf || ld_full;
    assign ld_store  = !ld_full && !eff_ovf;
    assign st_addr   = eff_count[IDX_W-1:0];

    assign dx    = (x_q >= r_lx) ? x_q - r_lx : r_lx - x_q;
    assign dy    = (y_q >= r_ly) ? y_q - r_ly : r_ly - y_q;
    assign sum_d = D_W'(r_sqx) + D_W'(r_sqy);

    // one step of the restoring square root
    assign rem_sh = {r_rem, r_sv[2*R_W-1 -: 2]};
    assign trial  = (R_W+4)'({r_root, 2'b01});

    assign acc_sum   = (LW+1)'(r_running) + (LW+1)'(r_root);
    assign n_running = (acc_sum > (LW+1)'(npp_pkg::LEN_MAX)) ? npp_pkg::LEN_MAX
                                                             : acc_sum[LW-1:0];
    assign abandon   = n_running > r_best;
    assign starts    = r_run_mode ? r_count : CNT_W'(1);

    assign rd_addr = (r_state == npp_pkg::S_SCAN) ? r_j[IDX_W-1:0] : r_s[IDX_W-1:0];

    always_comb begin
        vis_we = 1'b0;
        vis_wa = r_j[IDX_W-1:0];
        vis_d  = 1'b0;
        cur_we = 1'b0;
        cur_wa = '0;
        cur_wd = r_s[IDX_W-1:0];
        case (r_state)
            npp_pkg::S_CLR: begin
                vis_we = 1'b1;
            end
            npp_pkg::S_TSET: begin
                vis_we = 1'b1;
                vis_wa = r_s[IDX_W-1:0];
                vis_d  = 1'b1;
                cur_we = 1'b1;
            end
            npp_pkg::S_ACC: begin
                vis_we = !abandon;
                vis_wa = r_pick;
                vis_d  = 1'b1;
                cur_we = !abandon;
                cur_wa = r_k[IDX_W-1:0];
                cur_wd = r_pick;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == npp_pkg::OP_LOAD && ld_store) begin
            x_mem[st_addr] <= CB'(i_pad_x);
            y_mem[st_addr] <= CB'(i_pad_y);
        end
        x_q <= x_mem[rd_addr];
        y_q <= y_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_d;
        end
        vis_q <= vis_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            cur_mem[cur_wa] <= cur_wd;
        end
        cur_q <= cur_mem[r_c[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == npp_pkg::S_COPY && r_cv) begin
            best_mem[r_c1] <= cur_q;
        end
        best_q <= best_mem[IDX_W'(i_position)];
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_j1  <= r_j[IDX_W-1:0];
        r_j2  <= r_j1;
        r_vis2 <= vis_q;
        r_x2  <= x_q;
        r_y2  <= y_q;
        r_sqx <= SQ_W'(dx) * SQ_W'(dx);
        r_sqy <= SQ_W'(dy) * SQ_W'(dy);
        r_c1  <= r_c[IDX_W-1:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npp_pkg::S_IDLE;
            r_count     <= '0;
            r_closed    <= 1'b0;
            r_solved    <= 1'b0;
            r_ovf       <= 1'b0;
            r_mode      <= 1'b0;
            r_run_mode  <= 1'b0;
            r_best      <= npp_pkg::LEN_MAX;
            r_running   <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_cv        <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // issue marks for the scan and copy pipelines
            r_v1 <= (r_state == npp_pkg::S_SCAN) && (r_j < r_count);
            r_v2 <= r_v1;
            r_cv <= (r_state == npp_pkg::S_COPY) && (r_c < r_count);

            case (r_state)
                npp_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (i_operation == npp_pkg::OP_LOAD) begin
                            if (r_closed) begin
                                r_solved  <= 1'b0;
                                r_best    <= npp_pkg::LEN_MAX;
                                r_running <= '0;
                            end
                            r_closed <= i_last_pad;
                            r_ovf    <= ld_ovf;
                            r_count  <= ld_store ? eff_count + CNT_W'(1) : eff_count;
                            r_idx    <= ld_store ? st_addr : '0;
                            // best length is already all ones while a list is open
                            if (i_last_pad && !ld_ovf) begin
                                r_run_mode <= r_mode;
                                r_s        <= '0;
                                r_j        <= '0;
                                r_state    <= npp_pkg::S_CLR;
                            end else begin
                                r_out_valid <= 1'b1;
                                r_status    <= ld_ovf ? npp_pkg::ST_OVF : npp_pkg::ST_OK;
                                r_out_idx   <= ld_store ? st_addr : '0;
                                r_out_len   <= '0;
                            end
                        end else begin
                            r_state <= npp_pkg::S_RD;
                            if (r_ovf) begin
                                r_status <= npp_pkg::ST_OVF;
                            end else if (!r_solved || 32'(i_position) >= 32'(r_count)) begin
                                r_status <= npp_pkg::ST_BAD;
                            end else begin
                                r_status <= npp_pkg::ST_OK;
                            end
                        end
                    end
                end

                npp_pkg::S_RD: begin
                    r_out_valid <= 1'b1;
                    r_out_idx   <= (r_status == npp_pkg::ST_OK) ? best_q : '0;
                    r_out_len   <= (r_status == npp_pkg::ST_OK) ? r_best : '0;
                    r_state     <= npp_pkg::S_IDLE;
                end

                // clear visited marks of the list, store port reads the start pad
                npp_pkg::S_CLR: begin
                    r_j <= r_j + CNT_W'(1);
                    if (r_j + CNT_W'(1) >= r_count) begin
                        r_state <= npp_pkg::S_TSET;
                    end
                end

                npp_pkg::S_TSET: begin
                    r_lx      <= x_q;
                    r_ly      <= y_q;
                    r_k       <= CNT_W'(1);
                    r_running <= '0;
                    r_j       <= '0;
                    r_found   <= 1'b0;
                    if (r_count == CNT_W'(1)) begin
                        r_best <= '0;
                        r_c    <= '0;
                        r_state <= npp_pkg::S_COPY;
                    end else begin
                        r_state <= npp_pkg::S_SCAN;
                    end
                end

                // nearest search: issue, square, compare
                npp_pkg::S_SCAN: begin
                    if (r_j < r_count) begin
                        r_j  <= r_j + CNT_W'(1);
                    end
                    if (r_v2 && !r_vis2 && (!r_found || sum_d < r_bestd)) begin
                        r_found <= 1'b1;
                        r_bestd <= sum_d;
                        r_pick  <= r_j2;
                        r_px    <= r_x2;
                        r_py    <= r_y2;
                    end
                    if (r_j >= r_count && !r_v1 && !r_v2) begin
                        r_sv    <= (2*R_W)'(r_bestd) << (2 * npp_pkg::FRAC_BITS);
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_it    <= '0;
                        r_state <= npp_pkg::S_SQRT;
                    end
                end

                npp_pkg::S_SQRT: begin
                    r_sv <= r_sv << 2;
                    if (rem_sh >= trial) begin
                        r_rem  <= (R_W+2)'(rem_sh - trial);
                        r_root <= {r_root[R_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= (R_W+2)'(rem_sh);
                        r_root <= {r_root[R_W-2:0], 1'b0};
                    end
                    r_it <= r_it + IT_W'(1);
                    if (r_it == IT_W'(R_W - 1)) begin
                        r_state <= npp_pkg::S_ACC;
                    end
                end

                npp_pkg::S_ACC: begin
                    r_running <= n_running;
                    if (abandon) begin
                        r_state <= npp_pkg::S_NEXT;
                    end else begin
                        r_lx    <= r_px;
                        r_ly    <= r_py;
                        r_k     <= r_k + CNT_W'(1);
                        r_j     <= '0;
                        r_found <= 1'b0;
                        if (r_k + CNT_W'(1) >= r_count) begin
                            if (n_running <= r_best) begin
                                r_best  <= n_running;
                                r_c     <= '0;
                                r_state <= npp_pkg::S_COPY;
                            end else begin
                                r_state <= npp_pkg::S_NEXT;
                            end
                        end else begin
                            r_state <= npp_pkg::S_SCAN;
                        end
                    end
                end

                npp_pkg::S_COPY: begin
                    if (r_c < r_count) begin
                        r_c  <= r_c + CNT_W'(1);
                    end
                    if (r_c >= r_count && !r_cv) begin
                        r_state <= npp_pkg::S_NEXT;
                    end
                end

                npp_pkg::S_NEXT: begin
                    if (r_s + CNT_W'(1) >= starts) begin
                        r_solved    <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_status    <= npp_pkg::ST_OK;
                        r_out_idx   <= r_idx;
                        r_out_len   <= r_best;
                        r_state     <= npp_pkg::S_IDLE;
                    end else begin
                        r_s     <= r_s + CNT_W'(1);
                        r_j     <= '0;
                        r_state <= npp_pkg::S_CLR;
                    end
                end

                default: begin
                    r_state <= npp_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_pad_index   = 10'(r_out_idx);
    assign o_pad_count   = 11'(r_count);
    assign o_path_length = r_out_len;

`ifndef SYNTHESIS
    a_root_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npp_pkg::S_SQRT) |-> r_found)
        else $error("root step without a nearest pad");
    a_scan_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npp_pkg::S_SCAN) |-> (r_k < r_count))
        else $error("path step beyond pad count");
    a_ovf_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == npp_pkg::ST_OVF) |-> (o_path_length == '0))
        else $error("rejected list reports a length");
`endif

endmodule

[tb/nearest_neighbour_path_planner_unit_tb.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// nearest_neighbour_path_planner_unit_tb
// Drives pad lists and path reads through the planner under random idling and
// back-pressure, predicts each result beat with a behavioral path solver and
// compares every field in order. Covers both algorithm modes, distance ties,
// coordinate extremes, single-pad lists and unsolved and out-of-range reads.
// -----------------------------------------------------------------------------
module nearest_neighbour_path_planner_unit_tb;

    localparam int PADS = npp_pkg::MAX_PADS_DEF;

    typedef struct packed {
        logic [1:0]  st;
        logic [9:0]  idx;
        logic [10:0] cnt;
        logic [30:0] len;
    } t_result_beat;

    // -------------------------------------------------------------------------
    // Scoreboard: holds a behavioral copy of the planner and the queue of
    // result beats still owed by the block.
    // -------------------------------------------------------------------------
    class t_path_scoreboard;
        logic [11:0] px [PADS];
        logic [11:0] py [PADS];
        bit          seen [PADS];
        logic [9:0]  tour [PADS];
        logic [9:0]  best_tour [PADS];
        int unsigned n_pads;
        logic [30:0] best_len;
        logic [30:0] run_len;
        bit          solved;
        bit          ovf;
        bit          closed;
        bit          mode;
        t_result_beat owed [$];
        int          bad;
        int          lists_solved;
        int          lists_rejected;
        int          reads_ok;

        function new();
            n_pads = 0;
            best_len = npp_pkg::LEN_MAX;
            run_len = 0;
            solved = 0;
            ovf = 0;
            closed = 0;
            mode = 0;
            bad = 0;
        endfunction

        // integer square root, one result bit at a time
        function longint unsigned root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (longint'(1) << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function longint unsigned gap_sq(int a, int b);
            longint signed dx;
            longint signed dy;
            dx = longint'(px[a]) - longint'(px[b]);
            dy = longint'(py[a]) - longint'(py[b]);
            return longint'(dx * dx) + longint'(dy * dy);
        endfunction

        // greedy walk from one start; 0 when abandoned against the best
        function bit walk(int start);
            int here;
            int pick;
            bit got;
            longint unsigned dmin;
            longint unsigned d;
            longint unsigned sum;
            here = start;
            for (int i = 0; i < PADS; i++) seen[i] = 0;
            run_len = 0;
            tour[0] = 10'(start);
            seen[start] = 1;
            for (int k = 1; k < n_pads; k++) begin
                got = 0;
                pick = 0;
                dmin = 0;
                for (int j = 0; j < n_pads; j++) begin
                    if (!seen[j]) begin
                        d = gap_sq(here, j);
                        if (!got || d < dmin) begin
                            got = 1;
                            dmin = d;
                            pick = j;
                        end
                    end
                end
                sum = longint'(run_len) + root(dmin << 16);
                run_len = (sum > longint'(npp_pkg::LEN_MAX)) ? npp_pkg::LEN_MAX : sum[30:0];
                if (run_len > best_len) return 0;
                tour[k] = 10'(pick);
                seen[pick] = 1;
                here = pick;
            end
            return 1;
        endfunction

        function void solve_list();
            int starts;
            starts = mode ? n_pads : 1;
            best_len = npp_pkg::LEN_MAX;
            for (int s = 0; s < starts; s++) begin
                if (walk(s) && run_len <= best_len) begin
                    best_len = run_len;
                    for (int i = 0; i < n_pads; i++) best_tour[i] = tour[i];
                end
            end
            solved = 1;
            lists_solved++;
        endfunction

        function void note_beat(logic op, logic [11:0] x, logic [11:0] y,
                                logic last, logic [9:0] pos);
            t_result_beat e;
            e = '0;
            if (op == npp_pkg::OP_LOAD) begin
                if (closed) begin
                    n_pads = 0;
                    solved = 0;
                    ovf = 0;
                    best_len = npp_pkg::LEN_MAX;
                    run_len = 0;
                    closed = 0;
                end
                if (n_pads >= PADS) begin
                    ovf = 1;
                end else if (!ovf) begin
                    e.idx = 10'(n_pads);
                    px[n_pads] = x;
                    py[n_pads] = y;
                    n_pads++;
                end
                if (last) begin
                    closed = 1;
                    if (ovf) lists_rejected++;
                    else solve_list();
                end
                if (ovf) begin
                    e.st = npp_pkg::ST_OVF;
                    e.idx = '0;
                end else if (solved) begin
                    e.len = best_len;
                end
            end else begin
                if (ovf) begin
                    e.st = npp_pkg::ST_OVF;
                end else if (!solved || pos >= n_pads) begin
                    e.st = npp_pkg::ST_BAD;
                end else begin
                    e.st = npp_pkg::ST_OK;
                    e.idx = best_tour[pos];
                    e.len = best_len;
                    reads_ok++;
                end
            end
            e.cnt = 11'(n_pads);
            owed.push_back(e);
        endfunction

        function void check_beat(t_result_beat got);
            t_result_beat e;
            if (owed.size() == 0) begin
                bad++;
                if (bad <= 10) $display("unexpected result beat %p", got);
                return;
            end
            e = owed.pop_front();
            if (got !== e) begin
                bad++;
                if (bad <= 10)
                    $display("result beat differs: expected st=%0d idx=%0d cnt=%0d len=%0d, got st=%0d idx=%0d cnt=%0d len=%0d",
                             e.st, e.idx, e.cnt, e.len, got.st, got.idx, got.cnt, got.len);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [11:0] i_pad_x;
    logic [11:0] i_pad_y;
    logic        i_last_pad;
    logic [9:0]  i_position;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [9:0]  o_pad_index;
    logic [10:0] o_pad_count;
    logic [30:0] o_path_length;

    t_path_scoreboard sb;
    bit  calm;          // no idling on either side while set
    bit  hold_req;      // asks the receiver for one long hold-off
    int  beats_sent;

    nearest_neighbour_path_planner_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_pad_x      (i_pad_x),
        .i_pad_y      (i_pad_y),
        .i_last_pad   (i_last_pad),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_pad_index  (o_pad_index),
        .o_pad_count  (o_pad_count),
        .o_path_length(o_path_length)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #50_000_000;
        $display("nearest_neighbour_path_planner_unit: mismatch");
        $finish;
    end

    // Receiver: checks each accepted result beat, then picks next ready.
    // A hold-off request keeps ready low long enough for the input to stall.
    initial begin : receiver
        int hold_cnt;
        hold_cnt = 0;
        i_out_ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_beat({o_status, o_pad_index, o_pad_count, o_path_length});
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = 300;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 14);
            end
        end
    end

    // one input beat; valid stays up across back-to-back beats
    task automatic send_beat(logic op, logic [11:0] x, logic [11:0] y,
                             logic last, logic [9:0] pos);
        if (!calm && $urandom_range(99) < 14) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_operation <= op;
        i_pad_x     <= x;
        i_pad_y     <= y;
        i_last_pad  <= last;
        i_position  <= pos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_beat(op, x, y, last, pos);
        beats_sent++;
    endtask

    task automatic load_pad(logic [11:0] x, logic [11:0] y, logic last);
        send_beat(npp_pkg::OP_LOAD, x, y, last, 10'($urandom_range(1023)));
    endtask

    task automatic read_at(logic [9:0] pos);
        send_beat(npp_pkg::OP_READ, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                  1'($urandom_range(1)), pos);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.owed.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // mode register is only touched with the block idle
    task automatic set_mode(bit m);
        drain();
        i_cfg_we   <= 1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 0;
        sb.mode = m;
    endtask

    task automatic tie_list();
        load_pad(12'd10, 12'd10, 0);
        load_pad(12'd12, 12'd10, 0);   // equidistant pair from the first pad
        load_pad(12'd8, 12'd10, 0);
        load_pad(12'd4095, 12'd4095, 0);
        load_pad(12'd0, 12'd0, 0);
        load_pad(12'd0, 12'd4095, 1);
    endtask

    initial begin : stimulus
        int n;
        int style;
        logic [11:0] x;
        logic [11:0] y;
        sb = new();
        calm = 0;
        hold_req = 0;
        beats_sent = 0;
        i_rst_n     = 0;
        i_cfg_we    = 0;
        i_cfg_data  = 0;
        i_in_valid  = 0;
        i_operation = npp_pkg::OP_LOAD;
        i_pad_x     = 0;
        i_pad_y     = 0;
        i_last_pad  = 0;
        i_position  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reads before any list, ties and extremes in both modes
        set_mode(0);
        read_at(10'd0);
        read_at(10'd1023);
        tie_list();
        read_at(10'd0);
        read_at(10'd5);
        read_at(10'd6);                // equal to the pad count, one past the last pad
        read_at(10'd1023);
        set_mode(1);
        tie_list();
        read_at(10'd2);
        read_at(10'd5);
        load_pad(12'd4095, 12'd0, 1);  // single-pad list
        read_at(10'd0);
        read_at(10'd1);

        // open list read, then a closed two-pad list
        set_mode(0);
        load_pad(12'd7, 12'd9, 0);
        read_at(10'd0);
        load_pad(12'd3, 12'd1, 1);
        read_at(10'd1);

        // random lists until the beat budget is spent
        for (int l = 0; beats_sent < 580; l++) begin
            if (l % 7 == 0) set_mode(1'($urandom_range(1)));
            calm = (l >= 12 && l < 24);
            if (l == 4) hold_req = 1;
            n = ($urandom_range(9) == 0) ? int'($urandom_range(9, 16))
                                         : int'($urandom_range(1, 8));
            style = $urandom_range(2);
            for (int p = 0; p < n; p++) begin
                case (style)
                    0: begin
                        x = 12'($urandom_range(4095));
                        y = 12'($urandom_range(4095));
                    end
                    1: begin
                        x = 12'($urandom_range(3));
                        y = 12'($urandom_range(3));
                    end
                    default: begin
                        x = 12'hF00 | 12'($urandom_range(255));
                        y = 12'hF00 | 12'($urandom_range(255));
                    end
                endcase
                // occasional stray read inside an open list
                if ($urandom_range(19) == 0) read_at(10'($urandom_range(1023)));
                load_pad(x, y, p == n - 1);
            end
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(4) == 0) read_at(10'($urandom_range(1023)));
                else read_at(10'($urandom_range(n)));
            end
        end
        calm = 0;

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d beats: %0d lists solved, %0d rejected, %0d path reads served",
                 beats_sent, sb.lists_solved, sb.lists_rejected, sb.reads_ok);
        if (sb.bad == 0 && sb.owed.size() == 0) begin
            $display("nearest_neighbour_path_planner_unit: match");
        end else begin
            $display("%0d bad beats, %0d still owed", sb.bad, sb.owed.size());
            $display("nearest_neighbour_path_planner_unit: mismatch");
        end
        $finish;
    end

endmodule
